@@ rtl/scuc32_pkg.sv @@
// Shared types, constants and the CRC-32 byte update for the start-code unit tracker.
`default_nettype none

package scuc32_pkg;

  localparam int unsigned NUM_STREAMS_DEF = 2;
  localparam int unsigned SIZE_WIDTH_DEF  = 16;

  localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [7:0]  MIN_SIZE_RST = 8'd40;
  localparam logic [15:0] SIZE_OUT_MAX = 16'hFFFF;
  localparam logic [7:0]  SC_ZERO      = 8'h00;
  localparam logic [7:0]  SC_ONE       = 8'h01;

  // configuration register indexes
  localparam logic CFG_ENABLE   = 1'b0;
  localparam logic CFG_MIN_SIZE = 1'b1;

  // record offered by one stream lane for the transaction in flight
  typedef struct packed {
    logic        emit;
    logic [31:0] crc;
    logic [31:0] start_pcr;
    logic [15:0] size;
  } unit_rec_t;

  // MSB-first CRC-32 update by one byte, no reflection
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/scuc32_lane.sv @@
// Per-stream start-code detector, running CRC, byte counter and unit record.
`default_nettype none

module scuc32_lane
  import scuc32_pkg::*;
#(
  parameter int unsigned SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        hit_i,
  input  wire logic        clear_open_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [31:0] pcr_now_i,
  input  wire logic [7:0]  min_size_i,
  output unit_rec_t        rec_o
);

  logic [1:0]            zr_q, zr_d;
  logic [31:0]           crc_q, crc_d;
  logic [SIZE_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic [31:0]           pcr_q, pcr_d;
  logic                  open_q, open_d;
  logic                  is_zero, is_one, start_code;

  assign is_zero    = (data_byte_i == SC_ZERO);
  assign is_one     = (data_byte_i == SC_ONE);
  assign start_code = (zr_q == 2'd2) && is_one;
  assign cnt_inc    = (cnt_q == '1) ? cnt_q : cnt_q + SIZE_WIDTH'(1);

  always_comb begin
    zr_d   = zr_q;
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    pcr_d  = pcr_q;
    open_d = open_q;
    priority if (clear_open_i) begin
      open_d = 1'b0;
    end else if (hit_i) begin
      priority if (zr_q <= 2'd1 && is_zero) begin
        zr_d  = zr_q + 2'd1;
        cnt_d = cnt_inc;
        crc_d = crc32_byte(crc_q, SC_ZERO);
      end else if (start_code) begin
        zr_d   = 2'd0;
        open_d = 1'b1;
        cnt_d  = SIZE_WIDTH'(1);
        crc_d  = crc32_byte(CRC_INIT, SC_ONE);
        pcr_d  = pcr_now_i;
      end else if (!(zr_q == 2'd2 && is_zero)) begin
        zr_d  = 2'd0;
        cnt_d = cnt_inc;
        crc_d = crc32_byte(crc_q, data_byte_i);
      end else begin
        // third or later leading zero: skipped
        zr_d = zr_q;
      end
    end else begin
      open_d = open_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zr_q   <= 2'd0;
      crc_q  <= 32'd0;
      cnt_q  <= '0;
      pcr_q  <= 32'd0;
      open_q <= 1'b0;
    end else begin
      zr_q   <= zr_d;
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      pcr_q  <= pcr_d;
      open_q <= open_d;
    end
  end

  always_comb begin
    rec_o.emit      = hit_i && start_code && open_q && (cnt_q >= SIZE_WIDTH'(min_size_i));
    rec_o.crc       = crc_q;
    rec_o.start_pcr = pcr_q;
    rec_o.size      = (cnt_q > SIZE_WIDTH'(SIZE_OUT_MAX)) ? SIZE_OUT_MAX : 16'(cnt_q);
  end

endmodule

`default_nettype wire

@@ rtl/start_code_unit_crc32.sv @@
// Top level of the start-code unit CRC-32 tracker.
//
// Each accepted transaction carries one elementary-stream byte, its stream and the current
// PCR. The byte is registered; once the output register is free, the stream's lane
// updates its zero run, CRC and count and, when a 00 00 01 start code closes a unit of at
// least the minimum size, a record lands in the output register. One byte is taken per
// cycle while the input is not stalled; the record of the byte 01 that closed its unit
// is registered as that byte leaves the input register, and an output stall can delay both.
// The input stalls only while both the input register and the output register hold and
// the output is stalled. Configuration is applied at once; a change of enable drops every
// open unit.
`default_nettype none

module start_code_unit_crc32
  import scuc32_pkg::*;
#(
  parameter int unsigned NUM_STREAMS = NUM_STREAMS_DEF,
  parameter int unsigned SIZE_WIDTH  = SIZE_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        stream_select_i,
  input  wire logic [31:0] pcr_now_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             unit_stream_o,
  output logic [31:0]      unit_crc_o,
  output logic [31:0]      unit_start_pcr_o,
  output logic [15:0]      unit_size_o
);

  logic       enable_q;
  logic [7:0] min_size_q;
  logic       clear_open;

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_sel_q;
  logic [31:0] s1_pcr_q;

  logic        out_valid_q;
  logic        out_stream_q;
  logic [31:0] out_crc_q;
  logic [31:0] out_pcr_q;
  logic [15:0] out_size_q;

  logic                   out_free, s1_adv, in_acc;
  logic [NUM_STREAMS-1:0] lane_hit;
  unit_rec_t              lane_rec [NUM_STREAMS];
  unit_rec_t              rec;

  // configuration
  assign clear_open = cfg_we_i && (cfg_idx_i == CFG_ENABLE) && (cfg_data_i[0] != enable_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b1;
      min_size_q <= MIN_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE:   enable_q   <= cfg_data_i[0];
        CFG_MIN_SIZE: min_size_q <= cfg_data_i;
        default:      enable_q   <= enable_q;
      endcase
    end
  end

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= data_byte_i;
      s1_sel_q  <= stream_select_i;
      s1_pcr_q  <= pcr_now_i;
    end
  end

  // stream lanes
  for (genvar g = 0; g < NUM_STREAMS; g++) begin : g_lane
    assign lane_hit[g] = s1_adv && enable_q && (32'(s1_sel_q) == g);

    scuc32_lane #(
      .SIZE_WIDTH(SIZE_WIDTH)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .hit_i       (lane_hit[g]),
      .clear_open_i(clear_open),
      .data_byte_i (s1_byte_q),
      .pcr_now_i   (s1_pcr_q),
      .min_size_i  (min_size_q),
      .rec_o       (lane_rec[g])
    );
  end

  always_comb begin
    rec = '0;
    for (int s = 0; s < NUM_STREAMS; s++) begin
      if (lane_hit[s]) begin
        rec = lane_rec[s];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= rec.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && rec.emit) begin
      out_stream_q <= s1_sel_q;
      out_crc_q    <= rec.crc;
      out_pcr_q    <= rec.start_pcr;
      out_size_q   <= rec.size;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign unit_stream_o    = out_stream_q;
  assign unit_crc_o       = out_crc_q;
  assign unit_start_pcr_o = out_pcr_q;
  assign unit_size_o      = out_size_q;

  // checks
  a_one_lane: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(lane_hit))
    else $error("more than one stream lane updated");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");

  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (unit_size_o != 16'd0))
    else $error("record with zero size");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_crc_q)))
    else $error("stalled record lost or changed");

endmodule

`default_nettype wire
